[hw/rtl/assert_macros.svh]
// Assertion macros shared by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define WTM_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define WTM_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WTM_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/wtm_pkg.sv]
// Shared widths, constants and control types of the throughput meter.
package wtm_pkg;

	// Field widths
	localparam int TIME_W     = 48;
	localparam int BYTE_CNT_W = 32;
	localparam int TOTAL_W    = 64;
	localparam int SPEED_W    = 32;
	localparam int PERIOD_W   = 16;
	localparam int LEN_W      = 6;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_C  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_D  = 3'd4;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
	localparam int NUM_OUT_WIN = 4;
	localparam int WSEL_W      = $clog2(NUM_OUT_WIN);
	localparam logic [LEN_W-1:0] WIN_LEN_RST [NUM_OUT_WIN] = '{6'd1, 6'd5, 6'd20, 6'd60};

	// Ring and window sizing
	localparam int RING_DEPTH  = 60;
	localparam int NUM_WINDOWS = 4;
	localparam int NUM_CALC    = (NUM_WINDOWS < NUM_OUT_WIN) ? NUM_WINDOWS : NUM_OUT_WIN;
	localparam int PTR_W       = $clog2(RING_DEPTH);
	localparam int SLOT_W      = PTR_W + 1;
	localparam int LC_W        = (LEN_W > SLOT_W) ? LEN_W : SLOT_W;

	// Rate arithmetic
	localparam int MS_PER_SEC = 1000;
	localparam logic [TOTAL_W-1:0] MUL_LIMIT = {TOTAL_W{1'b1}} / TOTAL_W'(MS_PER_SEC);

	// Serial divider
	localparam int DIV_NUM_W = TOTAL_W;
	localparam int DIV_DEN_W = TIME_W;
	localparam int DIV_Q_W   = SPEED_W;
	localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

	typedef struct packed {
		logic start;
		logic force_sat;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[hw/rtl/wtm_if.sv]
// Valid/ready channel interfaces for meter arrivals and reports.
interface wtm_in_if;
	import wtm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [BYTE_CNT_W-1:0] byte_count;
	logic [TIME_W-1:0]     now_ms;

	modport source (output valid, cmd, byte_count, now_ms, input ready);
	modport sink   (input valid, cmd, byte_count, now_ms, output ready);
endinterface

interface wtm_out_if;
	import wtm_pkg::*;
	logic               valid;
	logic               ready;
	logic               sampled;
	logic [SPEED_W-1:0] speed_a;
	logic [SPEED_W-1:0] speed_b;
	logic [SPEED_W-1:0] speed_c;
	logic [SPEED_W-1:0] speed_d;
	logic [SPEED_W-1:0] peak_a;
	logic [SPEED_W-1:0] peak_b;
	logic [SPEED_W-1:0] peak_c;
	logic [SPEED_W-1:0] peak_d;
	logic [SPEED_W-1:0] stall_seconds;

	modport source (output valid, sampled, speed_a, speed_b, speed_c, speed_d,
		peak_a, peak_b, peak_c, peak_d, stall_seconds, input ready);
	modport sink   (input valid, sampled, speed_a, speed_b, speed_c, speed_d,
		peak_a, peak_b, peak_c, peak_d, stall_seconds, output ready);
endinterface

[hw/rtl/wtm_div.sv]
// Bit-serial restoring divider with 32-bit saturating quotient.
`include "assert_macros.svh"

module wtm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtm_pkg::div_ctl_t             ctl,
	input  logic [wtm_pkg::DIV_NUM_W-1:0] num,
	input  logic [wtm_pkg::DIV_DEN_W-1:0] den,
	output wtm_pkg::div_sts_t             sts,
	output logic [wtm_pkg::DIV_Q_W-1:0]   quot
);
	import wtm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   acc_q;

	logic                 sat_now;
	logic [DIV_DEN_W:0]   trial;
	logic                 qbit;
	logic [DIV_DEN_W-1:0] rem_next;

	// Quotient overflows 32 bits exactly when the upper numerator half reaches the divisor
	assign sat_now = ctl.force_sat || (DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den);

	always_comb begin
		trial    = {rem_q, acc_q[DIV_Q_W-1]};
		qbit     = trial >= {1'b0, den_q};
		rem_next = qbit ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				if (sat_now) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(DIV_Q_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Low numerator bits shift out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			den_q <= den;
			if (sat_now) begin
				acc_q <= '1;
			end else begin
				rem_q <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
				acc_q <= num[DIV_Q_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= rem_next;
			acc_q <= {acc_q[DIV_Q_W-2:0], qbit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = acc_q;

	`WTM_NEXT(a_sat_done, clk, arst_n, ctl.start && ctl.force_sat, done_q && (acc_q == '1), "saturated divide did not finish at once")
	`WTM_IMPLY(a_fall_done, clk, arst_n, $fell(busy_q), done_q, "divider stopped without done")
	`WTM_NEXT(a_done_pulse, clk, arst_n, done_q && !ctl.start, !done_q, "done held longer than one cycle")

endmodule

[hw/rtl/windowed_throughput_meter_top.sv]
// Sliding-window throughput meter: byte total, sample ring, window rates, peaks, stall age.
//
// channel   dir  handshake      payload
// arrival   in   valid/ready    cmd, byte_count, now_ms
// report    out  valid/ready    sampled, speed_a..d, peak_a..d, stall_seconds
// cfg       in   cfg_we         cfg_idx, cfg_data (no read-back)
//
// An item that takes no sample and finds no stall marked is only accepted and evaluated.
// With a stall marked, the 32-step serial divider also turns the stall age into seconds.
// A sample adds a read of the newest entry, an address and a read step per window plus a
// multiply and a divide per window whose time moved, and the ring push.
// Reset restores the register defaults and clears the ring valid bits at once.
// The report register holds a result while report.ready is low; the next item is
// accepted and worked on meanwhile, and only its own result waits for the register.
`include "assert_macros.svh"

module windowed_throughput_meter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wtm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wtm_pkg::CFG_DATA_W-1:0] cfg_data,
	wtm_in_if.sink                         arrival,
	wtm_out_if.source                      report
);
	import wtm_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_EVAL      = 11'b000_0000_0010,
		ST_NEWEST    = 11'b000_0000_0100,
		ST_WIN_ADDR  = 11'b000_0000_1000,
		ST_WIN_RD    = 11'b000_0001_0000,
		ST_MUL       = 11'b000_0010_0000,
		ST_WIN_DIV   = 11'b000_0100_0000,
		ST_PUSH      = 11'b000_1000_0000,
		ST_STALL_GO  = 11'b001_0000_0000,
		ST_STALL_DIV = 11'b010_0000_0000,
		ST_FIN       = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  t;
		logic [TOTAL_W-1:0] bytes;
	} ring_entry_t;

	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
		input logic [LEN_W-1:0] len);
		logic [LC_W-1:0]   lc;
		logic [SLOT_W-1:0] sum;
		lc = LC_W'(len);
		if (lc == '0) lc = LC_W'(1);
		if (lc > LC_W'(RING_DEPTH)) lc = LC_W'(RING_DEPTH);
		sum = SLOT_W'(head) + SLOT_W'(RING_DEPTH) - SLOT_W'(lc);
		if (sum >= SLOT_W'(RING_DEPTH)) sum = sum - SLOT_W'(RING_DEPTH);
		return PTR_W'(sum);
	endfunction

	// Control state
	state_t              state_q;
	logic [PERIOD_W-1:0] period_q;
	logic [LEN_W-1:0]    win_len_q [NUM_OUT_WIN];
	logic [TOTAL_W-1:0]  total_q;
	logic [TIME_W-1:0]   last_sample_q;
	logic [TIME_W-1:0]   stall_start_q;
	logic [PTR_W-1:0]    head_q;
	logic [WSEL_W-1:0]   w_idx_q;
	logic [SPEED_W-1:0]  speed_q [NUM_OUT_WIN];
	logic [SPEED_W-1:0]  peak_q [NUM_OUT_WIN];
	logic                rep_valid_q;

	// Ring store
	ring_entry_t         ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] ring_vld_q;
	ring_entry_t         rd_data_q;
	logic                rd_valid_q;

	// Item and working registers
	logic                  cmd_q;
	logic [BYTE_CNT_W-1:0] count_q;
	logic [TIME_W-1:0]     now_q;
	logic                  sampled_q;
	logic [SPEED_W-1:0]    stall_sec_q;
	logic [TOTAL_W-1:0]    db_q;
	logic [TIME_W-1:0]     dt_q;

	// Report register
	logic               rep_sampled_q;
	logic [SPEED_W-1:0] rep_speed_q [NUM_OUT_WIN];
	logic [SPEED_W-1:0] rep_peak_q [NUM_OUT_WIN];
	logic [SPEED_W-1:0] rep_stall_q;

	// Combinational
	logic                  in_acc;
	logic                  slot_free;
	logic [PTR_W-1:0]      newest_ptr;
	logic [PTR_W-1:0]      win_ptr;
	logic [PTR_W-1:0]      rd_addr;
	ring_entry_t           rd_entry;
	logic [TIME_W-1:0]     elapsed;
	logic [TIME_W-1:0]     stall_age;
	logic                  take_sample;
	logic                  fast_path;
	logic [TIME_W-1:0]     dt;
	logic [TOTAL_W-1:0]    db;
	logic                  emit;
	logic                  last_win;
	div_ctl_t              div_ctl;
	div_sts_t              div_sts;
	logic [DIV_NUM_W-1:0]  div_num;
	logic [DIV_DEN_W-1:0]  div_den;
	logic [DIV_Q_W-1:0]    div_quot;

	assign arrival.ready = (state_q == ST_IDLE);
	assign in_acc        = arrival.valid && arrival.ready;
	assign slot_free     = !rep_valid_q || report.ready;

	assign newest_ptr = (head_q == '0) ? PTR_W'(RING_DEPTH - 1) : head_q - PTR_W'(1);
	assign win_ptr    = slot_of(head_q, win_len_q[w_idx_q]);
	assign rd_addr    = (state_q == ST_WIN_ADDR) ? win_ptr : newest_ptr;
	assign rd_entry   = rd_valid_q ? rd_data_q : '0;

	assign elapsed     = now_q - last_sample_q;
	assign stall_age   = now_q - stall_start_q;
	assign take_sample = !cmd_q && (elapsed >= TIME_W'(period_q));
	assign fast_path   = cmd_q || (stall_start_q == '0);
	assign dt          = now_q - rd_entry.t;
	assign db          = total_q - rd_entry.bytes;
	assign last_win    = (w_idx_q == WSEL_W'(NUM_CALC - 1));

	assign emit = ((state_q == ST_EVAL) && !take_sample && fast_path && slot_free)
		|| ((state_q == ST_FIN) && slot_free);

	// Divider shared by the window rates and the stall age
	always_comb begin
		div_ctl.start     = (state_q == ST_MUL)
			|| ((state_q == ST_STALL_GO) && (stall_start_q != '0));
		div_ctl.force_sat = (state_q == ST_MUL) && (db_q > MUL_LIMIT);
		if (state_q == ST_MUL) begin
			// x1000 = x1024 - x16 - x8
			div_num = (db_q << 10) - (db_q << 4) - (db_q << 3);
			div_den = dt_q;
		end else begin
			div_num = DIV_NUM_W'(stall_age);
			div_den = DIV_DEN_W'(MS_PER_SEC);
		end
	end

	wtm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	// Ring memory and its valid bits
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH) ring_mem[head_q] <= '{t: now_q, bytes: total_q};
		rd_data_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUSH) ring_vld_q[head_q] <= 1'b1;
			rd_valid_q <= ring_vld_q[rd_addr];
		end
	end

	// Sequencer, configuration and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			period_q      <= PERIOD_RST;
			total_q       <= '0;
			last_sample_q <= '0;
			stall_start_q <= '0;
			head_q        <= '0;
			w_idx_q       <= '0;
			rep_valid_q   <= 1'b0;
			for (int w = 0; w < NUM_OUT_WIN; w++) begin
				win_len_q[w] <= WIN_LEN_RST[w];
				speed_q[w]   <= '0;
				peak_q[w]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_PERIOD: period_q     <= cfg_data[PERIOD_W-1:0];
					CFG_WIN_A:  win_len_q[0] <= cfg_data[LEN_W-1:0];
					CFG_WIN_B:  win_len_q[1] <= cfg_data[LEN_W-1:0];
					CFG_WIN_C:  win_len_q[2] <= cfg_data[LEN_W-1:0];
					CFG_WIN_D:  win_len_q[3] <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end

			if (emit) rep_valid_q <= 1'b1;
			else if (report.ready) rep_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!cmd_q) total_q <= total_q + TOTAL_W'(count_q);
					if (cmd_q) stall_start_q <= '0;
					priority if (take_sample) state_q <= ST_NEWEST;
					else if (fast_path) state_q <= slot_free ? ST_IDLE : ST_FIN;
					else state_q <= ST_STALL_GO;
				end
				ST_NEWEST: begin
					// No new bytes since the newest entry: mark the stall once
					if (total_q == rd_entry.bytes) begin
						if (stall_start_q == '0) stall_start_q <= now_q;
					end else begin
						stall_start_q <= '0;
					end
					w_idx_q <= '0;
					state_q <= ST_WIN_ADDR;
				end
				ST_WIN_ADDR: begin
					state_q <= ST_WIN_RD;
				end
				ST_WIN_RD: begin
					if (dt != '0) begin
						state_q <= ST_MUL;
					end else if (last_win) begin
						state_q <= ST_PUSH;
					end else begin
						w_idx_q <= w_idx_q + WSEL_W'(1);
						state_q <= ST_WIN_ADDR;
					end
				end
				ST_MUL: begin
					state_q <= ST_WIN_DIV;
				end
				ST_WIN_DIV: begin
					if (div_sts.done) begin
						speed_q[w_idx_q] <= div_quot;
						if (div_quot > peak_q[w_idx_q]) peak_q[w_idx_q] <= div_quot;
						if (last_win) begin
							state_q <= ST_PUSH;
						end else begin
							w_idx_q <= w_idx_q + WSEL_W'(1);
							state_q <= ST_WIN_ADDR;
						end
					end
				end
				ST_PUSH: begin
					head_q        <= (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
					last_sample_q <= now_q;
					state_q       <= ST_STALL_GO;
				end
				ST_STALL_GO: begin
					state_q <= (stall_start_q != '0) ? ST_STALL_DIV : ST_FIN;
				end
				ST_STALL_DIV: begin
					if (div_sts.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item, working and report payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= arrival.cmd;
			count_q <= arrival.byte_count;
			now_q   <= arrival.now_ms;
		end
		if (state_q == ST_EVAL) begin
			sampled_q   <= take_sample;
			stall_sec_q <= '0;
		end
		if (state_q == ST_WIN_RD) begin
			db_q <= db;
			dt_q <= dt;
		end
		if ((state_q == ST_STALL_DIV) && div_sts.done) stall_sec_q <= div_quot;
		if (emit) begin
			rep_sampled_q <= (state_q == ST_EVAL) ? 1'b0 : sampled_q;
			rep_stall_q   <= (state_q == ST_EVAL) ? '0 : stall_sec_q;
			for (int w = 0; w < NUM_OUT_WIN; w++) begin
				rep_speed_q[w] <= speed_q[w];
				rep_peak_q[w]  <= peak_q[w];
			end
		end
	end

	assign report.valid         = rep_valid_q;
	assign report.sampled       = rep_sampled_q;
	assign report.speed_a       = rep_speed_q[0];
	assign report.speed_b       = rep_speed_q[1];
	assign report.speed_c       = rep_speed_q[2];
	assign report.speed_d       = rep_speed_q[3];
	assign report.peak_a        = rep_peak_q[0];
	assign report.peak_b        = rep_peak_q[1];
	assign report.peak_c        = rep_peak_q[2];
	assign report.peak_d        = rep_peak_q[3];
	assign report.stall_seconds = rep_stall_q;

	`WTM_CHECK(a_head_range, clk, arst_n, head_q <= PTR_W'(RING_DEPTH - 1), "ring head out of range")
	`WTM_IMPLY(a_div_free, clk, arst_n, div_ctl.start, !div_sts.busy, "divider started while busy")
	`WTM_IMPLY(a_emit_free, clk, arst_n, emit, !rep_valid_q || report.ready, "report overwritten")

	for (genvar w = 0; w < NUM_OUT_WIN; w++) begin : g_peak
		`WTM_CHECK(a_peak_ge_speed, clk, arst_n, peak_q[w] >= speed_q[w], "peak below speed")
	end

endmodule
